FILE: hdl/kuf_pkg.sv
// Shared types and constants for the union-find Kruskal tail.
// Used by kuf_front, kuf_back and kruskal_union_find_threshold.
`default_nettype none
package kuf_pkg;
	localparam int NODE_W  = 10;
	localparam int LEN_W   = 24;
	localparam int LIM_W   = 16;
	localparam int NCNT_W  = 11;
	localparam int CNT_W   = 11;
	localparam int TOT_W   = 26;
	localparam int SUM_W   = 34;
	localparam int RANK_W  = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	// node store depth follows the endpoint field width
	localparam int MAX_NODES = 1 << NODE_W;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 8'd1;

	localparam logic REQ_CLEAR = 1'b0;
	localparam logic REQ_EDGE  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [LEN_W-1:0]  edge_length;
	} req_t;

	typedef struct packed {
		logic             joined;
		logic             over_limit;
		logic [CNT_W-1:0] component_count;
		logic [TOT_W-1:0] road_total;
		logic [TOT_W-1:0] track_total;
	} rsp_t;

	// queued command from front to back; road flag precomputed by the front
	typedef struct packed {
		logic              is_edge;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [LEN_W-1:0]  edge_length;
		logic              road;
	} cmd_t;
endpackage
`default_nettype wire

FILE: hdl/kuf_front.sv
// Front part: accepts requests, classifies edge lengths against the limit,
// and holds a two-word queue toward the back part. Uses kuf_pkg.
`default_nettype none
module kuf_front #(
	parameter int FRAC_BITS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  kuf_pkg::req_t       in_req,
	input  wire [kuf_pkg::LIM_W-1:0] length_limit,
	output logic                full,
	output logic                empty,
	output kuf_pkg::cmd_t       head,
	input  wire                 pop
);
	import kuf_pkg::*;

	localparam int LIMX_W = ((LIM_W + FRAC_BITS > LEN_W) ? LIM_W + FRAC_BITS : LEN_W) + 1;

	cmd_t slot_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t cmd;
	logic [LIMX_W-1:0] lim_x;
	logic [LIMX_W-1:0] len_x;

	always_comb begin
		lim_x = LIMX_W'(length_limit) << FRAC_BITS;
		len_x = LIMX_W'(in_req.edge_length);
		cmd.is_edge     = in_req.req_type == REQ_EDGE;
		cmd.node_a      = in_req.node_a;
		cmd.node_b      = in_req.node_b;
		cmd.edge_length = in_req.edge_length;
		cmd.road        = len_x <= lim_x;
	end

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && !full) slot_q[wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && !full) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && !full) - 2'(pop);
		end
	end

	pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	no_overflow: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !full && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("push lost");
endmodule
`default_nettype wire

FILE: hdl/kuf_back.sv
// Back part: union-find sequencer over parent and rank memories, with
// clearing sweep, path compression and saturating totals. Uses kuf_pkg.
`default_nettype none
module kuf_back #(
	parameter int FRAC_BITS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  empty,
	input  kuf_pkg::cmd_t        head,
	output logic                 pop,
	input  wire [kuf_pkg::NCNT_W-1:0] node_count,
	output logic                 idle,
	output logic                 rsp_valid,
	output kuf_pkg::rsp_t        rsp
);
	import kuf_pkg::*;

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = AW + 1;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_INIT  = 4'd1;
	localparam logic [3:0] ST_CLR   = 4'd2;
	localparam logic [3:0] ST_FRD   = 4'd3;
	localparam logic [3:0] ST_FCHK  = 4'd4;
	localparam logic [3:0] ST_CRD   = 4'd5;
	localparam logic [3:0] ST_CCHK  = 4'd6;
	localparam logic [3:0] ST_RRD   = 4'd7;
	localparam logic [3:0] ST_RCHK  = 4'd8;
	localparam logic [3:0] ST_LINK  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;
	localparam logic [3:0] ST_RBCHK = 4'd11;

	logic [AW-1:0] parent_mem [MAX_NODES];
	logic [RANK_W-1:0] rank_mem [MAX_NODES];

	logic [3:0] state_q;
	cmd_t cmd_q;
	logic side_q;           // 0: walking node_a, 1: node_b
	logic [AW-1:0] walk_q, top_q, ra_q, rb_q;
	logic [CW-1:0] clr_q, clr_end_q;
	logic [AW-1:0] par_rd_q;
	logic [RANK_W-1:0] rka_q, rkb_q;
	logic [AW-1:0] raddr;
	logic [RANK_W-1:0] rk_rd_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] road_q, track_q;
	logic joined_q, over_q;
	logic we;
	logic [AW-1:0] waddr, wdata;
	logic rwe;
	logic [AW-1:0] rwaddr;
	logic [RANK_W-1:0] rwdata;
	logic [SUM_W-1:0] len_x;
	logic [AW-1:0] start_node;

	function automatic logic [TOT_W-1:0] round_tot(input logic [SUM_W-1:0] s);
		logic [SUM_W:0] v;
		v = {1'b0, s};
		if (FRAC_BITS > 0) v = (v + ((SUM_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		round_tot = (v > (SUM_W+1)'({TOT_W{1'b1}})) ? {TOT_W{1'b1}} : v[TOT_W-1:0];
	endfunction

	assign len_x = SUM_W'(cmd_q.edge_length);
	assign start_node = side_q ? cmd_q.node_b[AW-1:0] : cmd_q.node_a[AW-1:0];

	always_comb begin
		raddr = walk_q;
		we = 1'b0; waddr = walk_q; wdata = top_q;
		rwe = 1'b0; rwaddr = clr_q[AW-1:0]; rwdata = '0;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				we = 1'b1; waddr = clr_q[AW-1:0]; wdata = clr_q[AW-1:0];
				rwe = 1'b1;
			end
			ST_CCHK: begin
				we = walk_q != top_q;
			end
			ST_RRD: raddr = ra_q;
			ST_RCHK: raddr = rb_q;
			ST_LINK: begin
				we = 1'b1;
				if (rka_q > rkb_q) begin
					waddr = rb_q; wdata = ra_q;
				end else begin
					waddr = ra_q; wdata = rb_q;
					rwaddr = rb_q; rwdata = rkb_q + 1'b1;
					rwe = (rka_q == rkb_q) && (rkb_q != RANK_MAX);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) parent_mem[waddr] <= wdata;
		if (rwe) rank_mem[rwaddr] <= rwdata;
		par_rd_q <= parent_mem[raddr];
		rk_rd_q  <= rank_mem[raddr];
	end

	assign pop = (state_q == ST_IDLE) && !empty;
	assign idle = (state_q == ST_IDLE) && empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			clr_end_q <= CW'(MAX_NODES);
			count_q <= CNT_W'(1);
			road_q <= '0;
			track_q <= '0;
			rsp_valid <= 1'b0;
			side_q <= 1'b0;
			joined_q <= 1'b0;
			over_q <= 1'b0;
		end else begin
			rsp_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (!empty) begin
					cmd_q <= head;
					joined_q <= 1'b0;
					over_q <= 1'b0;
					side_q <= 1'b0;
					if (head.is_edge) begin
						walk_q <= head.node_a[AW-1:0];
						state_q <= ST_FRD;
					end else begin
						count_q <= CNT_W'(1);
						road_q <= '0;
						track_q <= '0;
						clr_q <= '0;
						clr_end_q <= (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES)
							: CW'(node_count);
						state_q <= (node_count == '0) ? ST_OUT : ST_CLR;
					end
				end
				ST_INIT, ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q + 1'b1 == clr_end_q)
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_OUT;
				end
				ST_FRD: state_q <= ST_FCHK;   // read parent[walk]
				ST_FCHK: begin
					if (par_rd_q == walk_q) begin
						top_q <= walk_q;
						walk_q <= start_node;
						state_q <= ST_CRD;
					end else begin
						walk_q <= par_rd_q;
						state_q <= ST_FRD;
					end
				end
				ST_CRD: state_q <= ST_CCHK;
				ST_CCHK: begin
					// compress: point walk at root, step on
					if (walk_q == top_q) begin
						if (!side_q) begin
							ra_q <= top_q;
							side_q <= 1'b1;
							walk_q <= cmd_q.node_b[AW-1:0];
							state_q <= ST_FRD;
						end else begin
							rb_q <= top_q;
							state_q <= (ra_q == top_q) ? ST_OUT : ST_RRD;
						end
					end else begin
						walk_q <= par_rd_q;
						state_q <= ST_CRD;
					end
				end
				ST_RRD: state_q <= ST_RCHK;
				ST_RCHK: begin
					rka_q <= rk_rd_q;
					state_q <= ST_RBCHK;
				end
				ST_RBCHK: begin
					rkb_q <= rk_rd_q;
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					joined_q <= 1'b1;
					if (cmd_q.road) begin
						road_q <= (SUM_MAX - road_q < len_x) ? SUM_MAX : road_q + len_x;
					end else begin
						over_q <= 1'b1;
						track_q <= (SUM_MAX - track_q < len_x) ? SUM_MAX : track_q + len_x;
						if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					rsp_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rsp.joined <= joined_q;
		rsp.over_limit <= over_q;
		rsp.component_count <= count_q;
		rsp.road_total <= round_tot(road_q);
		rsp.track_total <= round_tot(track_q);
	end

	over_needs_join: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.over_limit || rsp.joined))
		else $error("over_limit without join");
	one_cycle_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid)
		else $error("result strobe held");
	pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != ST_IDLE)
		else $error("command popped but not started");
endmodule
`default_nettype wire

FILE: hdl/kruskal_union_find_threshold.sv
// Top level of the union-find Kruskal tail: config registers, front queue
// and union-find back part. Uses kuf_pkg, kuf_front, kuf_back.
//
// One request at a time runs in the back part. A clear sweeps the parent
// and rank memories over node_count nodes, node_count capped at MAX_NODES,
// one node a cycle, then outputs its result. An edge is popped, then each
// endpoint is found by walking parent links to its root and a compression
// pass points every node on the path at that root; when the sets differ the
// two root ranks are read and the roots linked, then the result is output.
// After reset a sweep over all MAX_NODES nodes initializes the memories;
// start is accepted into the two-word queue meanwhile. Results appear on
// result for one cycle with done high; the receiver cannot stall them.
`default_nettype none
module kruskal_union_find_threshold #(
	parameter int FRAC_BITS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  kuf_pkg::req_t        request,
	output logic                 done,
	output kuf_pkg::rsp_t        result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [kuf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [kuf_pkg::CFG_DAT_W-1:0] cfg_data
);
	import kuf_pkg::*;

	logic [LIM_W-1:0] length_limit_q;
	logic [NCNT_W-1:0] node_count_q;
	logic full, empty, pop, idle;
	cmd_t head;

	assign cfg_ready = 1'b1;
	assign busy = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_limit_q <= '0;
			node_count_q <= NCNT_W'(1024);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LENGTH_LIMIT: length_limit_q <= cfg_data[LIM_W-1:0];
				REG_NODE_COUNT:   node_count_q <= cfg_data[NCNT_W-1:0];
				default: ;
			endcase
		end
	end

	kuf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .in_req(request),
		.length_limit(length_limit_q), .full(full), .empty(empty),
		.head(head), .pop(pop)
	);

	kuf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(head), .pop(pop),
		.node_count(node_count_q), .idle(idle), .rsp_valid(done), .rsp(result)
	);

	busy_full: assert property (@(posedge clk) disable iff (!arst_n) busy |-> !idle)
		else $error("busy while back part idle");
	done_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(!idle))
		else $error("result without request");
	cfg_stable_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule
`default_nettype wire
